>>> rtl/udiv_pkg.sv
// Shared constants and types for the unsigned long divider.
// No dependencies; compile first.
package udiv_pkg;

  // Width of every magnitude field on the request and response channels.
  localparam int FIELD_WIDTH = 64;

  // Control bits that travel with each request down the divider pipeline.
  typedef struct packed {
    logic valid;
    logic dz;
    logic sign;
  } udiv_ctl_t;

endpackage

>>> rtl/udiv_if.sv
// Request and response channel interfaces for the unsigned long divider.
// Depends on udiv_pkg.
interface udiv_req_if import udiv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] numerator;
  logic [FIELD_WIDTH-1:0] denominator;
  logic                   numerator_sign;
  logic                   denominator_sign;

  modport source (
    output valid, numerator, denominator, numerator_sign, denominator_sign,
    input  ready
  );
  modport sink (
    input  valid, numerator, denominator, numerator_sign, denominator_sign,
    output ready
  );
endinterface

interface udiv_rsp_if import udiv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] quotient;
  logic [FIELD_WIDTH-1:0] remainder;
  logic                   quotient_sign;
  logic                   divide_by_zero;

  modport source (
    output valid, quotient, remainder, quotient_sign, divide_by_zero,
    input  ready
  );
  modport sink (
    input  valid, quotient, remainder, quotient_sign, divide_by_zero,
    output ready
  );
endinterface

>>> rtl/unsigned_long_divider.sv
// Unsigned long divider: a fully pipelined radix-2 restoring divider.
// Depends on udiv_pkg, udiv_req_if, udiv_rsp_if and udiv_stage.
//
// Each request carries a numerator and a denominator magnitude plus one sign
// bit per operand; each response returns the truncating quotient and
// remainder, a quotient sign equal to the XNOR of the two sign bits, and a
// divide-by-zero flag. A zero denominator returns all ones (DATA_WIDTH bits)
// in both quotient and remainder, sets divide_by_zero and clears
// quotient_sign. Only the low DATA_WIDTH bits of each magnitude are used;
// result bits above DATA_WIDTH read as zero. The divider is a chain of
// DATA_WIDTH register stages, one quotient bit per stage. The accepting edge
// loads the first stage, and the response becomes valid once the request
// has passed through the last stage. A new request can be accepted every
// cycle while the response side is not stalled. Each stage holds one
// (DATA_WIDTH+1)-bit subtract-and-compare (65 bits at the default width).
// When the response is not taken the whole pipeline holds and req.ready
// drops; nothing is lost or repeated.
module unsigned_long_divider import udiv_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  udiv_req_if.sink   req,
  udiv_rsp_if.source rsp
);

  // Stage k feeds stage k+1; index 0 is the incoming request.
  udiv_ctl_t             ctl [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nq  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den [0:DATA_WIDTH];
  logic                  advance;
  logic [DATA_WIDTH-1:0] den_in;

  // Advance the whole pipeline unless a finished response is waiting.
  assign advance   = !ctl[DATA_WIDTH].valid || rsp.ready;
  assign req.ready = advance;

  // Flag divide by zero up front and fold it into the sign.
  assign den_in        = req.denominator[DATA_WIDTH-1:0];
  assign ctl[0].valid  = req.valid;
  assign ctl[0].dz     = (den_in == '0);
  assign ctl[0].sign   = (den_in != '0) & ~(req.numerator_sign ^ req.denominator_sign);
  assign rem[0]        = '0;
  assign nq[0]         = req.numerator[DATA_WIDTH-1:0];
  assign den[0]        = den_in;

  // The numerator shifts out of the top of nq while quotient bits shift in.
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
    udiv_stage #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .ctl_in  (ctl[k]),
      .rem_in  (rem[k]),
      .nq_in   (nq[k]),
      .den_in  (den[k]),
      .ctl_out (ctl[k+1]),
      .rem_out (rem[k+1]),
      .nq_out  (nq[k+1]),
      .den_out (den[k+1])
    );
  end

  // Drive the response from the last stage; override both values on divide
  // by zero.
  assign rsp.valid          = ctl[DATA_WIDTH].valid;
  assign rsp.divide_by_zero = ctl[DATA_WIDTH].dz;
  assign rsp.quotient_sign  = ctl[DATA_WIDTH].sign;
  assign rsp.quotient       = ctl[DATA_WIDTH].dz ? FIELD_WIDTH'({DATA_WIDTH{1'b1}})
                                                 : FIELD_WIDTH'(nq[DATA_WIDTH]);
  assign rsp.remainder      = ctl[DATA_WIDTH].dz ? FIELD_WIDTH'({DATA_WIDTH{1'b1}})
                                                 : FIELD_WIDTH'(rem[DATA_WIDTH]);

  // Denominator copy out of the last stage is not used by any step logic.
  logic unused_den;
  assign unused_den = ^den[DATA_WIDTH];

endmodule

>>> rtl/udiv_stage.sv
// One restoring-division stage: resolves one quotient bit and registers it.
// Depends on udiv_pkg.
module udiv_stage import udiv_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  udiv_ctl_t             ctl_in,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] nq_in,
  input  logic [DATA_WIDTH-1:0] den_in,
  output udiv_ctl_t             ctl_out,
  output logic [DATA_WIDTH-1:0] rem_out,
  output logic [DATA_WIDTH-1:0] nq_out,
  output logic [DATA_WIDTH-1:0] den_out
);

  logic [DATA_WIDTH:0]   partial;
  logic [DATA_WIDTH:0]   diff;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] nq_next;

  // Shift in the next numerator bit; subtract when the divisor fits.
  always_comb begin
    partial  = {rem_in, nq_in[DATA_WIDTH-1]};
    diff     = partial - {1'b0, den_in};
    qbit     = (partial >= {1'b0, den_in});
    rem_next = qbit ? diff[DATA_WIDTH-1:0] : partial[DATA_WIDTH-1:0];
    nq_next  = {nq_in[DATA_WIDTH-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (advance) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl_out.dz   <= ctl_in.dz;
      ctl_out.sign <= ctl_in.sign;
      rem_out      <= rem_next;
      nq_out       <= nq_next;
      den_out      <= den_in;
    end
  end

endmodule

>>> rtl/udiv_checker.sv
// Port-level checks for the unsigned long divider, bound to the top level.
// Depends on udiv_pkg and unsigned_long_divider.
module udiv_checker import udiv_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [FIELD_WIDTH-1:0] quotient,
  input logic [FIELD_WIDTH-1:0] remainder,
  input logic                   quotient_sign,
  input logic                   divide_by_zero
);

  // Reset leaves no response pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // An empty output side never blocks a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request stalled with no response pending");

  // Divide by zero returns equal, nonzero values and a clear sign.
  a_dz_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && divide_by_zero |->
      !quotient_sign && quotient == remainder && quotient != '0)
    else $error("bad divide-by-zero response");

  // Result bits above the data width stay zero.
  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (quotient >> DATA_WIDTH) == '0 && (remainder >> DATA_WIDTH) == '0)
    else $error("response bits above data width set");

  // A stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(quotient) && $stable(remainder) &&
      $stable(quotient_sign) && $stable(divide_by_zero))
    else $error("stalled response changed");

endmodule

bind unsigned_long_divider udiv_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_udiv_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .quotient       (rsp.quotient),
  .remainder      (rsp.remainder),
  .quotient_sign  (rsp.quotient_sign),
  .divide_by_zero (rsp.divide_by_zero)
);
